// ===== hdl/arsw_pkg.sv =====
// ============================================================================
// Anti-replay sliding window: shared package
// Command codes, field widths and the control bundle for the counter block.
// ============================================================================
`default_nettype none

package arsw_pkg;

    localparam int SEQ_BITS   = 64;
    localparam int TOTAL_BITS = 32;
    localparam int WLEN_BITS  = 7;
    localparam int SLOTS_BITS = 7;

    localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic inc_accepted;
        logic inc_rejected;
    } cnt_ctrl_t;

endpackage : arsw_pkg

`default_nettype wire

// ===== hdl/arsw_window.sv =====
// ============================================================================
// Anti-replay sliding window: window state
// Holds the highest number seen and the slot bitmap, gives the freshness
// verdict and computes the next window, its bounds and the used slot count.
// ============================================================================
`default_nettype none

module arsw_window
    import arsw_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step_en,
    input  wire cmd_t                             command,
    input  wire logic [SEQ_BITS-1:0]              seq_num,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]  win_len,
    output logic                                  fresh,
    output logic [SEQ_BITS-1:0]                   highest_next,
    output logic [SEQ_BITS-1:0]                   lowest_next,
    output logic [SLOTS_BITS-1:0]                 slots_used_next
);

    localparam int W_BITS   = $clog2(WINDOW_MAX + 1);
    localparam int IDX_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam logic [WINDOW_MAX-1:0] BIT0 = WINDOW_MAX'(1);

    logic [SEQ_BITS-1:0]   highest_reg;
    logic [WINDOW_MAX-1:0] bitmap_reg;
    logic [WINDOW_MAX-1:0] bitmap_next;

    logic [SEQ_BITS-1:0]   age;
    logic [SEQ_BITS-1:0]   slide;
    logic [SEQ_BITS-1:0]   wsize_ext;
    logic                  is_empty;
    logic                  is_newer;
    logic                  age_in_win;
    logic [WINDOW_MAX-1:0] win_mask;
    logic [WINDOW_MAX-1:0] bitmap_slid;
    logic [W_BITS-1:0]     used_count;

    assign wsize_ext  = SEQ_BITS'(win_len);
    assign is_empty   = (highest_reg == '0);
    assign is_newer   = (seq_num > highest_reg);
    assign age        = highest_reg - seq_num;
    assign slide      = seq_num - highest_reg;
    assign age_in_win = (age < wsize_ext);

    // Only slots below the window length are checked; the rest read as seen.
    assign fresh = is_empty || is_newer ||
                   (age_in_win && !bitmap_reg[age[IDX_BITS-1:0]]);

    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            win_mask[i] = (W_BITS'(i) < win_len);
        end
    end

    // A slide of the window length or more empties the whole bitmap.
    assign bitmap_slid = (slide < wsize_ext)
                       ? ((bitmap_reg << slide[IDX_BITS-1:0]) & win_mask)
                       : '0;

    always_comb
    begin
        highest_next = highest_reg;
        bitmap_next  = bitmap_reg;
        unique case (command)
            CMD_UPDATE:
            begin
                if (fresh)
                begin
                    if (is_empty)
                    begin
                        highest_next = seq_num;
                        bitmap_next  = bitmap_reg | BIT0;
                    end
                    else if (is_newer)
                    begin
                        highest_next = seq_num;
                        bitmap_next  = bitmap_slid | BIT0;
                    end
                    else
                    begin
                        bitmap_next = bitmap_reg | (BIT0 << age[IDX_BITS-1:0]);
                    end
                end
            end
            CMD_CLEAR:
            begin
                highest_next = '0;
                bitmap_next  = '0;
            end
            default:
            begin
                highest_next = highest_reg;
                bitmap_next  = bitmap_reg;
            end
        endcase
    end

    always_comb
    begin
        if (highest_next == '0)
        begin
            lowest_next = '0;
        end
        else if (highest_next >= wsize_ext)
        begin
            lowest_next = highest_next - wsize_ext + SEQ_BITS'(1);
        end
        else
        begin
            lowest_next = SEQ_BITS'(1);
        end
    end

    always_comb
    begin
        used_count = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            used_count = used_count + W_BITS'(bitmap_next[i] & win_mask[i]);
        end
    end

    assign slots_used_next = SLOTS_BITS'(used_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg <= '0;
            bitmap_reg  <= '0;
        end
        else if (step_en)
        begin
            highest_reg <= highest_next;
            bitmap_reg  <= bitmap_next;
        end
    end

endmodule : arsw_window

`default_nettype wire

// ===== hdl/arsw_counters.sv =====
// ============================================================================
// Anti-replay sliding window: transaction counters
// Saturating counts of accepted and rejected numbers, cleared by command.
// ============================================================================
`default_nettype none

module arsw_counters
    import arsw_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step_en,
    input  wire cnt_ctrl_t              ctrl,
    output logic [TOTAL_BITS-1:0]       received_next,
    output logic [TOTAL_BITS-1:0]       replay_next
);

    logic [COUNTER_BITS-1:0] accepted_reg;
    logic [COUNTER_BITS-1:0] accepted_next;
    logic [COUNTER_BITS-1:0] rejected_reg;
    logic [COUNTER_BITS-1:0] rejected_next;

    always_comb
    begin
        accepted_next = accepted_reg;
        rejected_next = rejected_reg;
        if (ctrl.clear)
        begin
            accepted_next = '0;
            rejected_next = '0;
        end
        else
        begin
            if (ctrl.inc_accepted && (accepted_reg != '1))
            begin
                accepted_next = accepted_reg + COUNTER_BITS'(1);
            end
            if (ctrl.inc_rejected && (rejected_reg != '1))
            begin
                rejected_next = rejected_reg + COUNTER_BITS'(1);
            end
        end
    end

    assign received_next = TOTAL_BITS'(accepted_next);
    assign replay_next   = TOTAL_BITS'(rejected_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= '0;
            rejected_reg <= '0;
        end
        else if (step_en)
        begin
            accepted_reg <= accepted_next;
            rejected_reg <= rejected_next;
        end
    end

endmodule : arsw_counters

`default_nettype wire

// ===== hdl/anti_replay_sliding_window.sv =====
// ============================================================================
// Anti-replay sliding window
// Checks record sequence numbers against a sliding bitmap of recently seen
// numbers and reports the window bounds, the counters and the used slots.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    command, seq_num
//   out       out_valid / out_ready  accepted, highest_sequence,
//                                    lowest_sequence, received_total,
//                                    replay_total, slots_used
//   cfg       cfg_wr_en              cfg_wr_data (window length)
//
// One transaction per cycle while the output is not stalled; the check and update
// of the window state is combinational logic between the input register and the
// result register. An accepted transaction loads the input register, and the result
// register loads from it once the output can take it; out_valid rises with that load.
// Reset empties the window, clears the counters and sets the length to 64.
// While out_ready is low the result holds, the input register keeps its
// transaction, and in_ready drops once that register is full.
// ============================================================================
`default_nettype none

module anti_replay_sliding_window
    import arsw_pkg::*;
#(
    parameter int WINDOW_MAX   = 64,
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [WLEN_BITS-1:0]   cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             command,
    input  wire logic [SEQ_BITS-1:0]    seq_num,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        accepted,
    output logic [SEQ_BITS-1:0]         highest_sequence,
    output logic [SEQ_BITS-1:0]         lowest_sequence,
    output logic [TOTAL_BITS-1:0]       received_total,
    output logic [TOTAL_BITS-1:0]       replay_total,
    output logic [SLOTS_BITS-1:0]       slots_used
);

    localparam int W_BITS = $clog2(WINDOW_MAX + 1);

    logic [WLEN_BITS-1:0]  window_length_reg;
    logic [W_BITS-1:0]     w_eff;

    logic                  in_valid_reg;
    cmd_t                  command_reg;
    logic [SEQ_BITS-1:0]   seq_reg;

    logic                  out_valid_reg;
    logic                  accepted_reg;
    logic [SEQ_BITS-1:0]   highest_reg;
    logic [SEQ_BITS-1:0]   lowest_reg;
    logic [TOTAL_BITS-1:0] received_reg;
    logic [TOTAL_BITS-1:0] replay_reg;
    logic [SLOTS_BITS-1:0] slots_reg;

    logic                  step_en;
    logic                  fresh;
    logic [SEQ_BITS-1:0]   highest_next;
    logic [SEQ_BITS-1:0]   lowest_next;
    logic [SLOTS_BITS-1:0] slots_next;
    logic [TOTAL_BITS-1:0] received_next;
    logic [TOTAL_BITS-1:0] replay_next;
    cnt_ctrl_t             cnt_ctrl;

    // Zero acts as a one-slot window; lengths above the bitmap size are capped.
    always_comb
    begin
        priority if (window_length_reg == '0)
        begin
            w_eff = W_BITS'(1);
        end
        else if (int'(window_length_reg) > WINDOW_MAX)
        begin
            w_eff = W_BITS'(WINDOW_MAX);
        end
        else
        begin
            w_eff = W_BITS'(window_length_reg);
        end
    end

    assign step_en  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step_en;

    assign cnt_ctrl.clear        = (command_reg == CMD_CLEAR);
    assign cnt_ctrl.inc_accepted = (command_reg == CMD_UPDATE) && fresh;
    assign cnt_ctrl.inc_rejected = (command_reg == CMD_UPDATE) && !fresh;

    arsw_window #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_window (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (step_en),
        .command         (command_reg),
        .seq_num         (seq_reg),
        .win_len         (w_eff),
        .fresh           (fresh),
        .highest_next    (highest_next),
        .lowest_next     (lowest_next),
        .slots_used_next (slots_next)
    );

    arsw_counters #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_counters (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .ctrl          (cnt_ctrl),
        .received_next (received_next),
        .replay_next   (replay_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            command_reg <= cmd_t'(command);
            seq_reg     <= seq_num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            accepted_reg <= fresh && ((command_reg == CMD_UPDATE) ||
                                      (command_reg == CMD_CHECK));
            highest_reg  <= highest_next;
            lowest_reg   <= lowest_next;
            received_reg <= received_next;
            replay_reg   <= replay_next;
            slots_reg    <= slots_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = accepted_reg;
    assign highest_sequence = highest_reg;
    assign lowest_sequence  = lowest_reg;
    assign received_total   = received_reg;
    assign replay_total     = replay_reg;
    assign slots_used       = slots_reg;

`ifndef SYNTHESIS
    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((highest_sequence == '0) == (lowest_sequence == '0)) &&
                       (lowest_sequence <= highest_sequence)))
        else $error("window bounds inconsistent");

    a_slots_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(slots_used) <= int'(w_eff)))
        else $error("more used slots than window length");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (command_reg == CMD_CLEAR)) |=>
            (out_valid && !accepted && (received_total == '0) && (replay_total == '0)))
        else $error("clear did not reset counters");

    a_reject_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (command_reg == CMD_UPDATE)) |=>
            (accepted ? (received_total != '0) : (replay_total != '0)))
        else $error("update verdict not counted");
`endif

endmodule : anti_replay_sliding_window

`default_nettype wire

// ===== tb/testbench.sv =====
// ============================================================================
// Anti-replay sliding window testbench
// Drives sequence numbers and commands into the window checker under random
// sender bursts and receiver stalls. A local model of the window, bitmap and
// counters predicts each result, pinned directed rows give typed results, and each
// received transaction is compared field by field. A short directed table runs
// first, then random phases that each set a window length.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import arsw_pkg::*;

    localparam int SLOT_COUNT     = 64;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 106;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 30;

    // Command code 3 has no meaning for the block.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                  accepted;
        logic [SEQ_BITS-1:0]   highest;
        logic [SEQ_BITS-1:0]   lowest;
        logic [TOTAL_BITS-1:0] received;
        logic [TOTAL_BITS-1:0] replay;
        logic [SLOTS_BITS-1:0] slots;
    } verdict_t;

    typedef enum logic {ROW_ITEM, ROW_WINDOW} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [WLEN_BITS-1:0] wlen;
        logic [1:0]           cmd;
        logic [SEQ_BITS-1:0]  seq;
        logic                 pinned;
        verdict_t             typed;
    } stim_row_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} stall_mode_t;

    localparam verdict_t NO_VERDICT = '0;
    localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [WLEN_BITS-1:0]  cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            command = CMD_UPDATE;
    logic [SEQ_BITS-1:0]   seq_num = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  accepted;
    logic [SEQ_BITS-1:0]   highest_sequence;
    logic [SEQ_BITS-1:0]   lowest_sequence;
    logic [TOTAL_BITS-1:0] received_total;
    logic [TOTAL_BITS-1:0] replay_total;
    logic [SLOTS_BITS-1:0] slots_used;

    // Local copy of the window state.
    logic [WLEN_BITS-1:0]  window_reg = WINDOW_LENGTH_RESET;
    logic [SEQ_BITS-1:0]   win_high = '0;
    logic [SLOT_COUNT-1:0] win_map = '0;
    logic [TOTAL_BITS-1:0] rcv_count = '0;
    logic [TOTAL_BITS-1:0] rep_count = '0;

    verdict_t    verdict_q [$];
    verdict_t    oldest_verdict;
    stim_row_t   directed [0:27];

    stall_mode_t stall_mode = READY_ALWAYS;
    logic [9:0]  ready_pattern = 10'h3ff;
    int          pat_idx = 0;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int fresh_seen = 0;
    int window_writes = 0;
    int idle_cycles = 0;

    anti_replay_sliding_window uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .seq_num          (seq_num),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .highest_sequence (highest_sequence),
        .lowest_sequence  (lowest_sequence),
        .received_total   (received_total),
        .replay_total     (replay_total),
        .slots_used       (slots_used)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Register value to window length in slots; out-of-range values are clamped.
    function automatic int span_of(logic [WLEN_BITS-1:0] reg_value);
        if (reg_value == 0)
            return 1;
        if (reg_value > SLOT_COUNT)
            return SLOT_COUNT;
        return int'(reg_value);
    endfunction

    // Applies one transaction to the local window state and returns the result.
    function automatic verdict_t window_check(logic [1:0] cmd, logic [SEQ_BITS-1:0] seq);
        verdict_t              v;
        logic [SEQ_BITS-1:0]   span;
        logic [SEQ_BITS-1:0]   age;
        logic [SEQ_BITS-1:0]   jump;
        logic [SLOT_COUNT:0]   wide_mask;
        logic [SLOT_COUNT-1:0] mask;
        bit                    fresh;

        span      = span_of(window_reg);
        wide_mask = ({{SLOT_COUNT{1'b0}}, 1'b1} << span) - 1'b1;
        mask      = wide_mask[SLOT_COUNT-1:0];
        age       = win_high - seq;
        if (win_high == 0 || seq > win_high)
            fresh = 1'b1;
        else
            fresh = (age < span) && !win_map[age[5:0]];

        v = NO_VERDICT;
        case (cmd)
            CMD_UPDATE:
            begin
                if (fresh)
                begin
                    v.accepted = 1'b1;
                    if (win_high == 0)
                    begin
                        // The bitmap is not cleared here, so a zero that was
                        // accepted on an empty window stays marked.
                        win_high   = seq;
                        win_map[0] = 1'b1;
                    end
                    else if (seq > win_high)
                    begin
                        jump = seq - win_high;
                        if (jump >= span)
                            win_map = '0;
                        else
                            win_map = (win_map << jump[5:0]) & mask;
                        win_high   = seq;
                        win_map[0] = 1'b1;
                    end
                    else
                        win_map[age[5:0]] = 1'b1;
                    if (rcv_count != '1)
                        rcv_count = rcv_count + 1'b1;
                end
                else if (rep_count != '1)
                    rep_count = rep_count + 1'b1;
            end
            CMD_CHECK:
                v.accepted = fresh;
            CMD_CLEAR:
            begin
                win_high  = '0;
                win_map   = '0;
                rcv_count = '0;
                rep_count = '0;
            end
            default:
                ;
        endcase

        v.highest = win_high;
        if (win_high == 0)
            v.lowest = '0;
        else if (win_high >= span)
            v.lowest = win_high - span + 1'b1;
        else
            v.lowest = 1;
        v.received = rcv_count;
        v.replay   = rep_count;
        v.slots    = SLOTS_BITS'($countones(win_map & mask));
        return v;
    endfunction

    // Picks a number near the current window so that most transactions land on
    // its edges, inside it, or just above it.
    function automatic logic [SEQ_BITS-1:0] next_sequence();
        logic [SEQ_BITS-1:0] span;
        int                  r;

        span = span_of(window_reg);
        r    = $urandom_range(0, 99);
        if (r < 35)
            return win_high + $urandom_range(1, span + 2);
        else if (r < 65)
            return win_high - $urandom_range(0, span - 1);
        else if (r < 75)
            return win_high - span + $urandom_range(0, 1);
        else if (r < 82)
            return win_high + $urandom_range(span, 4 * span + 64);
        else if (r < 86)
            return ($urandom_range(0, 1) != 0) ? SEQ_MAX : '0;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [1:0] next_command();
        int r;

        r = $urandom_range(0, 99);
        if (r < 70)
            return CMD_UPDATE;
        else if (r < 85)
            return CMD_CHECK;
        else if (r < 89)
            return CMD_CLEAR;
        else if (r < 92)
            return CMD_UNUSED;
        return CMD_UPDATE;
    endfunction

    task automatic compare_field(string label, logic [SEQ_BITS-1:0] want,
                                 logic [SEQ_BITS-1:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Writes the window length once the block has gone idle.
    task automatic apply_window(logic [WLEN_BITS-1:0] value);
        in_valid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        window_reg = value;
        window_writes++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [1:0] cmd, logic [SEQ_BITS-1:0] seq,
                             bit pinned, verdict_t typed);
        verdict_t predicted;

        in_valid <= 1'b1;
        command  <= cmd;
        seq_num  <= seq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = window_check(cmd, seq);
        verdict_q.push_back(pinned ? typed : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic after_item();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    always @(negedge clk)
    begin
        case (stall_mode)
            READY_ALWAYS:
                out_ready <= 1'b1;
            READY_RANDOM:
                out_ready <= ($urandom_range(0, 9) < 7);
            default:
            begin
                out_ready <= ready_pattern[pat_idx];
                pat_idx   <= (pat_idx == 9) ? 0 : pat_idx + 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (accepted === 1'b1)
                fresh_seen++;
            if (verdict_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: result with no transaction waiting for it", $time);
            end
            else
            begin
                oldest_verdict = verdict_q.pop_front();
                compare_field("accepted", oldest_verdict.accepted, accepted);
                compare_field("highest_sequence", oldest_verdict.highest, highest_sequence);
                compare_field("lowest_sequence", oldest_verdict.lowest, lowest_sequence);
                compare_field("received_total", oldest_verdict.received, received_total);
                compare_field("replay_total", oldest_verdict.replay, replay_total);
                compare_field("slots_used", oldest_verdict.slots, slots_used);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, verdict_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [WLEN_BITS-1:0] wlen;

        directed = '{
            '{ROW_ITEM, 7'd0, CMD_CHECK, 64'd5, 1'b1, '{1'b1, 64'd0, 64'd0, 32'd0, 32'd0, 7'd0}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd0, 1'b1, '{1'b1, 64'd0, 64'd0, 32'd1, 32'd0, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd0, 1'b1, '{1'b1, 64'd0, 64'd0, 32'd2, 32'd0, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd100, 1'b1,
              '{1'b1, 64'd100, 64'd37, 32'd3, 32'd0, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd100, 1'b1,
              '{1'b0, 64'd100, 64'd37, 32'd3, 32'd1, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd37, 1'b1,
              '{1'b1, 64'd100, 64'd37, 32'd4, 32'd1, 7'd2}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd36, 1'b1,
              '{1'b0, 64'd100, 64'd37, 32'd4, 32'd2, 7'd2}},
            '{ROW_ITEM, 7'd0, CMD_CHECK, 64'd99, 1'b1,
              '{1'b1, 64'd100, 64'd37, 32'd4, 32'd2, 7'd2}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd99, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd102, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd300, 1'b1,
              '{1'b1, 64'd300, 64'd237, 32'd7, 32'd2, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UNUSED, 64'd300, 1'b1,
              '{1'b0, 64'd300, 64'd237, 32'd7, 32'd2, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, SEQ_MAX, 1'b1,
              '{1'b1, SEQ_MAX, 64'hFFFF_FFFF_FFFF_FFC0, 32'd8, 32'd2, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, SEQ_MAX - 1, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_CLEAR, 64'hA5A5_5A5A_A5A5_5A5A, 1'b1, NO_VERDICT},
            '{ROW_WINDOW, 7'd4, CMD_UPDATE, 64'd0, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd3, 1'b1, '{1'b1, 64'd3, 64'd1, 32'd1, 32'd0, 7'd1}},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd1, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd5, 1'b0, NO_VERDICT},
            // Shrinking keeps the upper slots until the next slide.
            '{ROW_WINDOW, 7'd2, CMD_UPDATE, 64'd0, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd4, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd3, 1'b0, NO_VERDICT},
            '{ROW_WINDOW, 7'd0, CMD_UPDATE, 64'd0, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd5, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd6, 1'b0, NO_VERDICT},
            '{ROW_WINDOW, 7'd127, CMD_UPDATE, 64'd0, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_UPDATE, 64'd5, 1'b0, NO_VERDICT},
            '{ROW_ITEM, 7'd0, CMD_CHECK, 64'd0, 1'b0, NO_VERDICT}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        stall_mode = READY_RANDOM;
        for (int i = 0; i < $size(directed); i++)
        begin
            if (directed[i].kind == ROW_WINDOW)
                apply_window(directed[i].wlen);
            else
            begin
                send_item(directed[i].cmd, directed[i].seq, directed[i].pinned,
                          directed[i].typed);
                after_item();
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: wlen = 7'd1;
                1: wlen = 7'd64;
                2: wlen = 7'd0;
                3: wlen = 7'd127;
                4: wlen = 7'd8;
                5: wlen = 7'd33;
                6: wlen = 7'd2;
                7: wlen = 7'd63;
                default: wlen = WLEN_BITS'($urandom_range(1, SLOT_COUNT));
            endcase
            apply_window(wlen);
            stall_mode    = stall_mode_t'(p % 3);
            ready_pattern = 10'($urandom) | 10'h001;
            gaps_on       = (p % 4) != 1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_item(next_command(), next_sequence(), 1'b0, NO_VERDICT);
                after_item();
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (6) @(negedge clk);

        $display("Run covered %0d transactions over %0d window length settings.",
                 items_sent, window_writes);
        $display("Checked %0d results, %0d of them fresh verdicts.", results_seen, fresh_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : testbench
